// ----- src/mhtb_pkg.sv -----
// mhtb_pkg: shared constants, command/status codes and item types for the
// magic hash table builder. No dependencies; every other file uses it.
package mhtb_pkg;

	localparam int MAX_INDEX_BITS = 12;
	localparam int MIN_INDEX_BITS = 5;
	localparam int TABLE_DEPTH    = 1 << MAX_INDEX_BITS;
	localparam int TOP_BYTE_SHIFT = 56;
	localparam int MIN_TOP_BITS   = 6;
	localparam int CNT_W          = 7;   // holds a 64-bit popcount

	localparam int DEF_QUEUE_DEPTH = 8;
	localparam int DEF_EPOCH_BITS  = 8;

	typedef enum logic [1:0] {
		CMD_BEGIN  = 2'd0,
		CMD_ENTRY  = 2'd1,
		CMD_LOOKUP = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_COLLISION = 3'd1,
		ST_REJECTED  = 3'd2,
		ST_BAD_SIZE  = 3'd3,
		ST_NO_TABLE  = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [63:0] magic;
		logic [63:0] blocking;
		logic [63:0] attack_set;
	} in_item_t;

	typedef struct packed {
		logic [2:0]                status;
		logic [MAX_INDEX_BITS-1:0] hash_index;
		logic [63:0]               attack_out;
		logic                      trial_failed;
	} out_item_t;

	// classified item handed from the front end to the table back end
	typedef struct packed {
		cmd_t                      cmd;
		logic                      size_ok;
		logic                      pre_ok;
		logic [MAX_INDEX_BITS-1:0] idx;
		logic [63:0]               attack;
	} work_item_t;

endpackage

// ----- src/mhtb_front.sv -----
// mhtb_front: input acceptance, mask register, pipelined 64-bit hash multiply
// and classification of each transaction. Depends on mhtb_pkg.
module mhtb_front #(
	parameter int QUEUE_DEPTH = mhtb_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  mhtb_pkg::in_item_t   request,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [63:0]          cfg_data,
	input  logic                 credit_ret,
	input  logic                 hold,
	output logic                 q_push,
	output mhtb_pkg::work_item_t q_item
);

	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
	localparam int MAXB  = mhtb_pkg::MAX_INDEX_BITS;
	localparam int CW    = mhtb_pkg::CNT_W;

	function automatic logic [CW-1:0] count_ones(input logic [63:0] v);
		logic [3:0]    byte_cnt;
		logic [CW-1:0] total;
		total = '0;
		for (int b = 0; b < 8; b++) begin
			byte_cnt = '0;
			for (int i = 0; i < 8; i++) begin
				byte_cnt = byte_cnt + 4'(v[8*b+i]);
			end
			total = total + CW'(byte_cnt);
		end
		return total;
	endfunction

	logic [63:0]      mask_q;
	logic [CW-1:0]    n_q;
	logic [63:0]      trial_magic_q;
	logic [OCC_W-1:0] occ_q;

	logic accept, take;

	logic                 v_s1, v_s2, v_s3;
	mhtb_pkg::cmd_t       cmd_s1, cmd_s2, cmd_s3;
	logic [63:0]          att_s1, att_s2, att_s3;
	logic [63:0]          a_s1, b_s1;
	logic [63:0]          p_ll_s2;
	logic [31:0]          p_lh_s2, p_hl_s2;
	logic [63:0]          prod_s3;

	logic            is_begin;
	logic            size_ok, pre_ok;
	logic [CW-1:0]   shamt;
	logic [MAXB-1:0] top_bits;

	assign cfg_ready = 1'b1;
	// credits cover the three multiply stages plus the queue
	assign full      = (occ_q == OCC_W'(QUEUE_DEPTH)) || hold;
	assign accept    = push && !full;
	assign take      = accept && (request.cmd != mhtb_pkg::CMD_NONE);
	assign is_begin  = (request.cmd == mhtb_pkg::CMD_BEGIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q        <= '0;
			n_q           <= '0;
			trial_magic_q <= '0;
			occ_q         <= '0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
		end else begin
			if (cfg_valid) begin
				mask_q <= cfg_data;
				n_q    <= count_ones(cfg_data);
			end
			if (take && is_begin) begin
				trial_magic_q <= request.magic;
			end
			occ_q <= occ_q + OCC_W'(take) - OCC_W'(credit_ret);
			v_s1  <= take;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= mhtb_pkg::cmd_t'(request.cmd);
			att_s1 <= request.attack_set;
			a_s1   <= is_begin ? mask_q : (request.blocking & mask_q);
			b_s1   <= is_begin ? request.magic : trial_magic_q;
		end
		// low 64 bits of the product from three 32x32 partial products
		cmd_s2  <= cmd_s1;
		att_s2  <= att_s1;
		p_ll_s2 <= a_s1[31:0] * b_s1[31:0];
		p_lh_s2 <= a_s1[31:0] * b_s1[63:32];
		p_hl_s2 <= a_s1[63:32] * b_s1[31:0];
		cmd_s3  <= cmd_s2;
		att_s3  <= att_s2;
		prod_s3 <= p_ll_s2 + {p_lh_s2 + p_hl_s2, 32'b0};
	end

	always_comb begin
		size_ok  = (n_q >= CW'(mhtb_pkg::MIN_INDEX_BITS)) && (n_q <= CW'(MAXB));
		pre_ok   = count_ones({56'b0, prod_s3[63:mhtb_pkg::TOP_BYTE_SHIFT]})
			>= CW'(mhtb_pkg::MIN_TOP_BITS);
		shamt    = CW'(MAXB) - n_q;
		top_bits = prod_s3[63 -: MAXB];

		q_push         = v_s3;
		q_item.cmd     = cmd_s3;
		q_item.size_ok = size_ok;
		q_item.pre_ok  = pre_ok;
		q_item.idx     = top_bits >> shamt;
		q_item.attack  = att_s3;
	end

endmodule

// ----- src/mhtb_queue.sv -----
// mhtb_queue: short FIFO of classified items between front and back end.
// Depends on mhtb_pkg; DEPTH must be a power of two.
module mhtb_queue #(
	parameter int DEPTH = mhtb_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  mhtb_pkg::work_item_t wr_item,
	input  logic                 rd_en,
	output logic                 not_empty,
	output mhtb_pkg::work_item_t rd_item
);

	localparam int PTR_W = $clog2(DEPTH);

	mhtb_pkg::work_item_t slots_q [DEPTH];
	logic [PTR_W:0]       wr_ptr_q, rd_ptr_q;

	assign not_empty = (wr_ptr_q != rd_ptr_q);
	assign rd_item   = slots_q[rd_ptr_q[PTR_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) slots_q[wr_ptr_q[PTR_W-1:0]] <= wr_item;
	end

endmodule

// ----- src/mhtb_back.sv -----
// mhtb_back: attack table memory with epoch tags, trial state, clearing
// sweep and the result register. Depends on mhtb_pkg.
module mhtb_back #(
	parameter int EPOCH_BITS = mhtb_pkg::DEF_EPOCH_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  mhtb_pkg::work_item_t q_item,
	output logic                 q_pop,
	output logic                 clearing,
	output logic                 empty,
	input  logic                 pop,
	output mhtb_pkg::out_item_t  result
);

	localparam int MAXB   = mhtb_pkg::MAX_INDEX_BITS;
	localparam int WORD_W = EPOCH_BITS + 64;

	// word = {epoch tag, attack set}; a slot is in use when its tag is current
	logic [WORD_W-1:0] table_mem [mhtb_pkg::TABLE_DEPTH];

	logic                  clr_busy_q;
	logic [MAXB-1:0]       clr_addr_q;
	logic [EPOCH_BITS-1:0] epoch_q;
	logic                  ready_q, failed_q;

	logic                 v_s2;
	mhtb_pkg::work_item_t item_s2;
	logic [WORD_W-1:0]    rd_s2;
	logic                 fwd_s2;
	logic [63:0]          fwd_data_s2;

	logic                out_valid_q;
	mhtb_pkg::out_item_t out_q;

	logic             out_free, advance, load, wrap, wr_fire;
	logic             slot_hit;
	logic [63:0]      slot_att;
	mhtb_pkg::status_t st;
	logic [MAXB-1:0]  idx_o;
	logic [63:0]      aout;
	logic             ready_n, failed_n, wr_en, bump;

	assign clearing = clr_busy_q;
	assign empty    = !out_valid_q;
	assign result   = out_q;
	assign out_free = !out_valid_q || pop;
	assign advance  = v_s2 && out_free && !clr_busy_q;
	assign wr_fire  = advance && wr_en;
	// an item must not read ahead of a sweep that its predecessor starts
	assign load     = q_valid && !clr_busy_q && (!v_s2 || advance) && !(advance && wrap);
	assign q_pop    = load;

	always_comb begin
		slot_hit = fwd_s2 || (rd_s2[WORD_W-1:64] == epoch_q);
		slot_att = fwd_s2 ? fwd_data_s2 : rd_s2[63:0];
		st       = mhtb_pkg::ST_OK;
		idx_o    = '0;
		aout     = '0;
		ready_n  = ready_q;
		failed_n = failed_q;
		wr_en    = 1'b0;
		bump     = 1'b0;
		unique case (item_s2.cmd)
			mhtb_pkg::CMD_BEGIN: begin
				bump = 1'b1;
				if (!item_s2.size_ok) begin
					st       = mhtb_pkg::ST_BAD_SIZE;
					ready_n  = 1'b0;
					failed_n = 1'b1;
				end else if (!item_s2.pre_ok) begin
					st       = mhtb_pkg::ST_REJECTED;
					ready_n  = 1'b0;
					failed_n = 1'b1;
				end else begin
					ready_n  = 1'b1;
					failed_n = 1'b0;
				end
			end
			mhtb_pkg::CMD_ENTRY, mhtb_pkg::CMD_LOOKUP: begin
				if (!item_s2.size_ok) begin
					st = mhtb_pkg::ST_BAD_SIZE;
				end else if (!ready_q) begin
					st = mhtb_pkg::ST_NO_TABLE;
				end else begin
					idx_o = item_s2.idx;
					if (item_s2.cmd == mhtb_pkg::CMD_ENTRY) begin
						if (!slot_hit) begin
							wr_en = 1'b1;
						end else if (slot_att != item_s2.attack) begin
							st       = mhtb_pkg::ST_COLLISION;
							failed_n = 1'b1;
						end
					end else begin
						aout = slot_hit ? slot_att : 64'd0;
					end
				end
			end
			default: begin
			end
		endcase
		wrap = bump && (epoch_q == {EPOCH_BITS{1'b1}});
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			table_mem[clr_addr_q] <= '0;
		end else if (wr_fire) begin
			table_mem[item_s2.idx] <= {epoch_q, item_s2.attack};
		end
		if (load) begin
			rd_s2 <= table_mem[q_item.idx];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s2 <= q_item;
			// same-slot write on this edge is not yet in the read data
			fwd_s2      <= wr_fire && (q_item.idx == item_s2.idx);
			fwd_data_s2 <= item_s2.attack;
		end
		if (advance) begin
			out_q.status       <= st;
			out_q.hash_index   <= idx_o;
			out_q.attack_out   <= aout;
			out_q.trial_failed <= failed_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q  <= 1'b1;
			clr_addr_q  <= '0;
			epoch_q     <= '0;
			ready_q     <= 1'b0;
			failed_q    <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == {MAXB{1'b1}}) clr_busy_q <= 1'b0;
			end else if (advance && wrap) begin
				clr_busy_q <= 1'b1;
			end
			if (advance) begin
				ready_q  <= ready_n;
				failed_q <= failed_n;
				if (bump) epoch_q <= wrap ? EPOCH_BITS'(1) : epoch_q + 1'b1;
			end
			if (load) begin
				v_s2 <= 1'b1;
			end else if (advance) begin
				v_s2 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- src/magic_hash_table_builder_unit.sv -----
// Top level of the magic hash table builder: front end, item queue, table
// back end. Depends on mhtb_pkg, mhtb_front, mhtb_queue, mhtb_back.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------
//   input    | push / full          | request (cmd, magic, blocking, attack_set)
//   result   | pop / empty          | result (status, hash_index, attack_out, trial_failed)
//   config   | cfg_valid/cfg_ready  | cfg_data (occupancy_mask)
//
// One transaction per cycle sustained while results are popped and no sweep
// runs; six register stages (three multiply stages, the queue, the table read,
// the result register), the first loaded by the accepting edge.
// The table memory takes a read per item and a write per new entry.
// After reset a clearing sweep over all 4096 table slots holds full high; the same
// sweep runs once every 2**EPOCH_BITS - 1 begin items (first after 2**EPOCH_BITS).
// A stalled result only backs up the queue; push stalls when it is full.
module magic_hash_table_builder_unit #(
	parameter int QUEUE_DEPTH = mhtb_pkg::DEF_QUEUE_DEPTH,
	parameter int EPOCH_BITS  = mhtb_pkg::DEF_EPOCH_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  mhtb_pkg::in_item_t  request,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [63:0]         cfg_data,
	output logic                empty,
	input  logic                pop,
	output mhtb_pkg::out_item_t result
);

	logic                 fq_push, q_pop, q_valid, clearing;
	mhtb_pkg::work_item_t fq_item, q_item;

	mhtb_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.request    (request),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.credit_ret (q_pop),
		.hold       (clearing),
		.q_push     (fq_push),
		.q_item     (fq_item)
	);

	mhtb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (fq_push),
		.wr_item   (fq_item),
		.rd_en     (q_pop),
		.not_empty (q_valid),
		.rd_item   (q_item)
	);

	mhtb_back #(.EPOCH_BITS(EPOCH_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.clearing (clearing),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

// ----- src/mhtb_checker.sv -----
// mhtb_checker: port-level assertions on the builder's result channel,
// bound to magic_hash_table_builder_unit. Depends on mhtb_pkg.
module mhtb_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                push,
	input logic                full,
	input mhtb_pkg::in_item_t  request,
	input logic                cfg_valid,
	input logic                cfg_ready,
	input logic [63:0]         cfg_data,
	input logic                empty,
	input logic                pop,
	input mhtb_pkg::out_item_t result
);

	a_fail_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result.status == mhtb_pkg::ST_COLLISION
			|| result.status == mhtb_pkg::ST_REJECTED)) |-> result.trial_failed)
		else $error("failing status without trial_failed");

	a_attack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status != mhtb_pkg::ST_OK) |-> (result.attack_out == 64'd0))
		else $error("attack_out nonzero on a non-ok result");

	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result.status == mhtb_pkg::ST_BAD_SIZE
			|| result.status == mhtb_pkg::ST_NO_TABLE)) |-> (result.hash_index == '0))
		else $error("hash_index nonzero without a table");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result changed while stalled");

endmodule

bind magic_hash_table_builder_unit mhtb_checker u_chk (.*);
